### sv/page_run_first_fit_allocator_top_macros.svh
// assertion helpers for the page run allocator
`ifndef PAGE_RUN_FIRST_FIT_ALLOCATOR_TOP_MACROS_SVH
`define PAGE_RUN_FIRST_FIT_ALLOCATOR_TOP_MACROS_SVH

// clocked check, off while in reset
`define PRFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check of what must hold in the cycle after a condition
`define PRFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/prfa_pkg.sv
package prfa_pkg;

  localparam int unsigned PAGE_COUNT      = 32768;
  localparam int unsigned PAGE_BITS       = $clog2(PAGE_COUNT);
  localparam int unsigned PAGE_SHIFT      = 12;
  localparam int unsigned MAX_BLOCK_PAGES = 255;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSPACE = 3'd1;
  localparam logic [2:0] ST_BADSIZE = 3'd2;
  localparam logic [2:0] ST_BADADDR = 3'd3;
  localparam logic [2:0] ST_FREE    = 3'd4;

  // one run head entry, all zero when not a head
  typedef struct packed {
    logic [15:0] len;
    logic [15:0] prior;
    logic [31:0] bytes;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

### sv/prfa_ram.sv
module prfa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/page_run_first_fit_allocator_top.sv
// Page run allocator. One command is taken when start is high and busy is low; exactly one
// result follows, shown for one cycle with done_o, and it cannot be held off. After reset the
// run store is swept once, one entry a cycle, with busy high; region_base may be written at
// any time while busy is low. Every command walks a simple dual-port run store (one read
// port, one write port) through a small sequencer: a query reads the run head; a free reads
// the head, merges it with a free run after it and with one before it, and sets the prior link
// of the run that follows; a bad address, a free of a free run or a refused size ends without a
// write; an allocation tries the cursor, else scans run heads from page zero for a first fit.
module page_run_first_fit_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [31:0] request_bytes_i,
  input  logic [31:0] target_address_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] granted_address_o,
  output logic [31:0] stored_bytes_o,
  output logic [27:0] span_bytes_o
);
  import prfa_pkg::*;
  `include "page_run_first_fit_allocator_top_macros.svh"

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FAST  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_TAKE  = 4'd4;
  localparam logic [3:0] S_TAKE2 = 4'd5;
  localparam logic [3:0] S_PRI   = 4'd6;
  localparam logic [3:0] S_F0    = 4'd7;
  localparam logic [3:0] S_F1    = 4'd8;
  localparam logic [3:0] S_F2    = 4'd9;
  localparam logic [3:0] S_F3    = 4'd10;
  localparam logic [3:0] S_F4    = 4'd11;
  localparam logic [3:0] S_FA    = 4'd12;
  localparam logic [3:0] S_Q     = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  localparam logic [16:0] PageEnd = 17'(PAGE_COUNT);

  logic [3:0]           state_q, state_d;
  logic [PAGE_BITS-1:0] cnt_q, cnt_d;
  logic [15:0]          cursor_q, cursor_d;
  logic [31:0]          base_q;
  logic [31:0]          req_q, req_d;
  logic [15:0]          pages_q, pages_d;
  logic [PAGE_BITS-1:0] head_q, head_d, idx_q, idx_d, tgt_q, tgt_d;
  logic [16:0]          i_q, i_d;
  logic [15:0]          len_q, len_d, prior_q, prior_d, val_q, val_d;
  logic [2:0]           status_q, status_d;
  logic [31:0]          granted_q, granted_d, stored_q, stored_d;
  logic [27:0]          span_q, span_d;

  logic                 ram_we;
  logic [PAGE_BITS-1:0] ram_waddr, ram_raddr;
  entry_t               ram_wdata, rd;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic [31:0]          off;
  logic                 addr_ok;
  logic [16:0]          sum_a, sum_b;
  logic [15:0]          rest;
  logic                 rd_fits, rd_free_run;

  assign rd          = entry_t'(ram_rdata);
  assign rd_fits     = (rd.len >= pages_q) && (rd.bytes == 32'd0);
  assign rd_free_run = (rd.bytes == 32'd0) && (rd.len != 16'd0);
  assign off         = target_address_i - base_q;
  assign addr_ok     = (target_address_i >= base_q) && (off[PAGE_SHIFT-1:0] == '0) &&
                       (off[31:PAGE_SHIFT+PAGE_BITS] == '0);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cursor_d  = cursor_q;
    req_d     = req_q;
    pages_d   = pages_q;
    head_d    = head_q;
    idx_d     = idx_q;
    tgt_d     = tgt_q;
    i_d       = i_q;
    len_d     = len_q;
    prior_d   = prior_q;
    val_d     = val_q;
    status_d  = status_q;
    granted_d = granted_q;
    stored_d  = stored_q;
    span_d    = span_q;
    ram_we    = 1'b0;
    ram_waddr = tgt_q;
    ram_wdata = '0;
    ram_raddr = '0;
    sum_a     = '0;
    sum_b     = '0;
    rest      = '0;
    case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        if (cnt_q == '0) begin
          ram_wdata.len = 16'(PAGE_COUNT);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          status_d  = ST_OK;
          granted_d = '0;
          stored_d  = '0;
          span_d    = '0;
          req_d     = request_bytes_i;
          pages_d   = 16'(request_bytes_i[31:PAGE_SHIFT]) + 16'd1;
          idx_d     = off[PAGE_SHIFT+PAGE_BITS-1:PAGE_SHIFT];
          ram_raddr = off[PAGE_SHIFT+PAGE_BITS-1:PAGE_SHIFT];
          case (operation_i)
            OP_ALLOC: begin
              if (request_bytes_i == '0 ||
                  request_bytes_i[31:PAGE_SHIFT] >= (32-PAGE_SHIFT)'(MAX_BLOCK_PAGES)) begin
                status_d = ST_BADSIZE;
                state_d  = S_DONE;
              end else if (17'(cursor_q) < PageEnd) begin
                ram_raddr = cursor_q[PAGE_BITS-1:0];
                head_d    = cursor_q[PAGE_BITS-1:0];
                state_d   = S_FAST;
              end else begin
                ram_raddr = '0;
                i_d       = '0;
                state_d   = S_SCAN;
              end
            end
            OP_FREE, OP_QUERY: begin
              if (!addr_ok) begin
                status_d = ST_BADADDR;
                state_d  = S_DONE;
              end else begin
                state_d = (operation_i == OP_FREE) ? S_F0 : S_Q;
              end
            end
            default: begin
              status_d = ST_BADSIZE;
              state_d  = S_DONE;
            end
          endcase
        end
      end
      S_FAST: begin
        len_d   = rd.len;
        prior_d = rd.prior;
        if (rd_fits) begin
          state_d = S_TAKE;
        end else begin
          ram_raddr = '0;
          i_d       = '0;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        len_d   = rd.len;
        prior_d = rd.prior;
        head_d  = i_q[PAGE_BITS-1:0];
        // walk run heads, stepping one page over a non-head
        sum_a   = i_q + ((rd.len == '0) ? 17'd1 : 17'(rd.len));
        if (rd_fits) begin
          state_d = S_TAKE;
        end else if (sum_a >= PageEnd) begin
          status_d = ST_NOSPACE;
          state_d  = S_DONE;
        end else begin
          i_d       = sum_a;
          ram_raddr = sum_a[PAGE_BITS-1:0];
        end
      end
      S_TAKE: begin
        ram_we    = 1'b1;
        ram_waddr = head_q;
        ram_wdata = '{len: pages_q, prior: prior_q, bytes: req_q};
        rest      = len_q - pages_q;
        sum_a     = 17'(head_q) + 17'(pages_q);
        cursor_d  = sum_a[15:0];
        granted_d = base_q + (32'(head_q) << PAGE_SHIFT);
        tgt_d     = sum_a[PAGE_BITS-1:0];
        val_d     = rest;
        state_d   = (rest != '0 && sum_a < PageEnd) ? S_TAKE2 : S_DONE;
      end
      S_TAKE2: begin
        // remainder head behind the granted pages
        ram_we    = 1'b1;
        ram_wdata = '{len: val_q, prior: pages_q, bytes: 32'd0};
        sum_a     = 17'(tgt_q) + 17'(val_q);
        ram_raddr = sum_a[PAGE_BITS-1:0];
        tgt_d     = sum_a[PAGE_BITS-1:0];
        state_d   = (sum_a < PageEnd) ? S_PRI : S_DONE;
      end
      S_PRI: begin
        ram_we    = 1'b1;
        ram_wdata = '{len: rd.len, prior: val_q, bytes: rd.bytes};
        state_d   = S_DONE;
      end
      S_F0: begin
        len_d   = rd.len;
        prior_d = rd.prior;
        head_d  = idx_q;
        sum_a   = 17'(idx_q) + 17'(rd.len);
        tgt_d   = sum_a[PAGE_BITS-1:0];
        ram_raddr = sum_a[PAGE_BITS-1:0];
        if (rd.bytes == '0) begin
          status_d = ST_FREE;
          state_d  = S_DONE;
        end else begin
          state_d = (sum_a < PageEnd) ? S_F1 : S_F2;
        end
      end
      S_F1: begin
        // forward merge
        if (rd_free_run) begin
          len_d     = len_q + rd.len;
          ram_we    = 1'b1;
          ram_wdata = '0;
        end
        state_d = S_F2;
      end
      S_F2: begin
        sum_b     = 17'(idx_q) - 17'(prior_q);
        ram_raddr = sum_b[PAGE_BITS-1:0];
        if (prior_q != '0 && 17'(prior_q) <= 17'(idx_q)) begin
          state_d = S_F3;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = idx_q;
          ram_wdata = '{len: len_q, prior: prior_q, bytes: 32'd0};
          state_d   = S_FA;
        end
      end
      S_F3: begin
        sum_b = 17'(idx_q) - 17'(prior_q);
        ram_we = 1'b1;
        if (rd_free_run) begin
          // backward merge into the free run before
          head_d    = sum_b[PAGE_BITS-1:0];
          len_d     = len_q + rd.len;
          ram_waddr = sum_b[PAGE_BITS-1:0];
          ram_wdata = '{len: len_q + rd.len, prior: rd.prior, bytes: rd.bytes};
          state_d   = S_F4;
        end else begin
          ram_waddr = idx_q;
          ram_wdata = '{len: len_q, prior: prior_q, bytes: 32'd0};
          state_d   = S_FA;
        end
      end
      S_F4: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = '0;
        state_d   = S_FA;
      end
      S_FA: begin
        sum_a     = 17'(head_q) + 17'(len_q);
        ram_raddr = sum_a[PAGE_BITS-1:0];
        tgt_d     = sum_a[PAGE_BITS-1:0];
        val_d     = len_q;
        state_d   = (sum_a < PageEnd) ? S_PRI : S_DONE;
      end
      S_Q: begin
        stored_d = rd.bytes;
        span_d   = 28'({rd.len, PAGE_SHIFT'(0)});
        state_d  = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      cnt_q    <= '0;
      cursor_q <= '0;
      base_q   <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      cursor_q <= cursor_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    pages_q   <= pages_d;
    head_q    <= head_d;
    idx_q     <= idx_d;
    tgt_q     <= tgt_d;
    i_q       <= i_d;
    len_q     <= len_d;
    prior_q   <= prior_d;
    val_q     <= val_d;
    status_q  <= status_d;
    granted_q <= granted_d;
    stored_q  <= stored_d;
    span_q    <= span_d;
  end

  prfa_ram #(
    .Width (ENTRY_W),
    .Depth (PAGE_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy              = (state_q != S_IDLE);
  assign done_o            = (state_q == S_DONE);
  assign status_o          = status_q;
  assign granted_address_o = granted_q;
  assign stored_bytes_o    = stored_q;
  assign span_bytes_o      = span_q;

  `PRFA_ASSERT_NEXT(a_take_busy, start && !busy, busy, "accepted word did not raise busy")
  `PRFA_ASSERT_NEXT(a_done_once, done_o, !done_o, "result strobe longer than one cycle")
  `PRFA_ASSERT(a_fail_no_grant, (done_o && status_o != ST_OK) |-> (granted_address_o == '0),
               "failed command carries an address")
  `PRFA_ASSERT(a_status_code, done_o |-> (status_o <= ST_FREE), "status code out of range")

endmodule
